// ----- rtl/aaf_pkg.sv -----
`timescale 1ns / 1ps

package aaf_pkg;

    // Widths of the fixed-point datapath.
    localparam int WORD_W = 32;
    localparam int MAG_W  = 97;   // magnitude of one perpendicular component
    localparam int U_W    = 30;   // normalized component magnitude
    localparam int IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_AXIS_POINT_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_AXIS_POINT_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_AXIS_POINT_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_AXIS_DIR_X   = 3'd3;
    localparam logic [IDX_W-1:0] REG_AXIS_DIR_Y   = 3'd4;
    localparam logic [IDX_W-1:0] REG_AXIS_DIR_Z   = 3'd5;
    localparam logic [IDX_W-1:0] REG_ACCEL_GAIN   = 3'd6;

    localparam logic [WORD_W-1:0] DIR_Z_RESET = 32'h0001_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic        [WORD_W-1:0] mass;
    } particle_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] force_x;
        logic signed [WORD_W-1:0] force_y;
        logic signed [WORD_W-1:0] force_z;
        logic                     on_axis;
    } force_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] point_x;
        logic signed [WORD_W-1:0] point_y;
        logic signed [WORD_W-1:0] point_z;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] dir_z;
        logic signed [WORD_W-1:0] gain;
    } axis_cfg_t;

    // One classified particle: perpendicular magnitudes, their signs, the
    // on-axis flag and the mass that still has to be applied.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            negw;
        logic                  on_axis;
        logic [WORD_W-1:0]     mass;
    } perp_t;

endpackage

// ----- rtl/aaf_if.sv -----
`timescale 1ns / 1ps

interface aaf_particle_if;
    logic                valid;
    logic                ready;
    aaf_pkg::particle_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface aaf_force_if;
    logic             valid;
    logic             ready;
    aaf_pkg::force_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/axial_attraction_force.sv -----
`timescale 1ns / 1ps

// Axial attraction force.
// The particle channel takes one beat per particle (position and mass). The
// result channel gives one beat per particle: the force toward the closest
// point of the configured axis, scaled by the gain and the mass, each
// component saturated to Q16.16, plus an on-axis flag that marks a particle
// on the axis or a zero axis direction (force then zero).
// Configuration is a plain write port; the user must write registers only
// while no particle is in flight, the block itself does not enforce it.
// Throughput is one particle per cycle while the receiver does not stall.
// The accepting edge loads the first of 7 front stages that form the
// perpendicular exactly; the particle then passes the queue, 6 normalize
// and square stages, 31 square-root stages, 31 divider stages and 3
// scaling and saturation stages on its way to the result beat. The root
// and the divider retire one bit per stage.
// Reset empties both pipelines and the queue and loads the register reset
// values (axis along +z through the origin, gain zero).
// When the receiver stalls, the back pipeline holds; the front keeps taking
// particles until the queue fills, and only then drops ready.
module axial_attraction_force #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [aaf_pkg::IDX_W-1:0]     cfg_index,
    input  logic [aaf_pkg::WORD_W-1:0]    cfg_data,
    aaf_particle_if.sink                  particle,
    aaf_force_if.source                   result
);

    aaf_pkg::axis_cfg_t cfg_reg;

    // Register file; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            cfg_reg.dir_z <= aaf_pkg::DIR_Z_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aaf_pkg::REG_AXIS_POINT_X: cfg_reg.point_x <= cfg_data;
                aaf_pkg::REG_AXIS_POINT_Y: cfg_reg.point_y <= cfg_data;
                aaf_pkg::REG_AXIS_POINT_Z: cfg_reg.point_z <= cfg_data;
                aaf_pkg::REG_AXIS_DIR_X:   cfg_reg.dir_x   <= cfg_data;
                aaf_pkg::REG_AXIS_DIR_Y:   cfg_reg.dir_y   <= cfg_data;
                aaf_pkg::REG_AXIS_DIR_Z:   cfg_reg.dir_z   <= cfg_data;
                aaf_pkg::REG_ACCEL_GAIN:   cfg_reg.gain    <= cfg_data;
                default:                   cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // The front classifies, the queue decouples, the back does the math.
    logic           push_valid, push_ready;
    logic           pop_valid, pop_ready;
    aaf_pkg::perp_t push_data, pop_data;

    aaf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (particle.valid),
        .in_ready   (particle.ready),
        .in_data    (particle.data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    aaf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    aaf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (cfg_reg.gain),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );

    // A particle flagged on the axis must carry no force at all.
    a_on_axis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.on_axis |->
            result.data.force_x == 32'sd0 && result.data.force_y == 32'sd0
            && result.data.force_z == 32'sd0)
        else $error("on-axis result with nonzero force");

endmodule

// ----- rtl/aaf_front.sv -----
`timescale 1ns / 1ps

// Seven-stage pipeline that forms the exact perpendicular
// W = v*(d.d) - d*(v.d) and classifies the particle as on or off the axis.
module aaf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  aaf_pkg::axis_cfg_t  cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  aaf_pkg::particle_t  in_data,
    output logic                push_valid,
    input  logic                push_ready,
    output aaf_pkg::perp_t      push_data
);

    logic signed [31:0] pos [3];
    logic signed [31:0] pt  [3];
    logic signed [31:0] dir [3];

    assign pos[0] = in_data.pos_x;
    assign pos[1] = in_data.pos_y;
    assign pos[2] = in_data.pos_z;
    assign pt[0]  = cfg.point_x;
    assign pt[1]  = cfg.point_y;
    assign pt[2]  = cfg.point_z;
    assign dir[0] = cfg.dir_x;
    assign dir[1] = cfg.dir_y;
    assign dir[2] = cfg.dir_z;

    logic [6:0] vld_reg;
    logic       en;

    assign en         = !vld_reg[6] || push_ready;
    assign in_ready   = en;
    assign push_valid = vld_reg[6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    logic signed [32:0] v1_reg  [3];
    logic signed [32:0] v2_reg  [3];
    logic signed [32:0] v3_reg  [3];
    logic signed [63:0] dd2_reg [3];
    logic signed [64:0] vd2_reg [3];
    logic signed [64:0] s3_reg;
    logic signed [65:0] t3_reg;
    logic signed [65:0] psl4_reg [3];
    logic signed [65:0] psh4_reg [3];
    logic signed [64:0] ptl4_reg [3];
    logic signed [65:0] pth4_reg [3];
    logic signed [97:0] sv5_reg [3];
    logic signed [97:0] td5_reg [3];
    logic signed [97:0] w6_reg  [3];
    logic [aaf_pkg::MAG_W-1:0] mag7_reg [3];
    logic [2:0]         negw7_reg;
    logic               zero7_reg;
    logic [31:0]        mass_reg [7];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mass_reg[0] <= in_data.mass;
            for (int j = 1; j < 7; j++)
            begin
                mass_reg[j] <= mass_reg[j-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i]   <= $signed({pos[i][31], pos[i]}) - $signed({pt[i][31], pt[i]});
                dd2_reg[i]  <= dir[i] * dir[i];
                vd2_reg[i]  <= v1_reg[i] * dir[i];
                v2_reg[i]   <= v1_reg[i];
                v3_reg[i]   <= v2_reg[i];
                psl4_reg[i] <= $signed({1'b0, s3_reg[31:0]}) * v3_reg[i];
                psh4_reg[i] <= $signed(s3_reg[64:32]) * v3_reg[i];
                ptl4_reg[i] <= $signed({1'b0, t3_reg[31:0]}) * dir[i];
                pth4_reg[i] <= $signed(t3_reg[65:32]) * dir[i];
                sv5_reg[i]  <= $signed({psh4_reg[i], 32'b0}) + 98'(psl4_reg[i]);
                td5_reg[i]  <= $signed({pth4_reg[i], 32'b0}) + 98'(ptl4_reg[i]);
                w6_reg[i]   <= sv5_reg[i] - td5_reg[i];
                mag7_reg[i] <= w6_reg[i][97] ? 97'(-w6_reg[i]) : w6_reg[i][96:0];
                negw7_reg[i] <= w6_reg[i][97];
            end
            s3_reg    <= 65'(dd2_reg[0]) + 65'(dd2_reg[1]) + 65'(dd2_reg[2]);
            t3_reg    <= 66'(vd2_reg[0]) + 66'(vd2_reg[1]) + 66'(vd2_reg[2]);
            zero7_reg <= (w6_reg[0] == 98'sd0) && (w6_reg[1] == 98'sd0)
                         && (w6_reg[2] == 98'sd0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            push_data.mag[i] = mag7_reg[i];
        end
        push_data.negw    = negw7_reg;
        push_data.on_axis = zero7_reg;
        push_data.mass    = mass_reg[6];
    end

endmodule

// ----- rtl/aaf_fifo.sv -----
`timescale 1ns / 1ps

// Short queue between the front and back pipelines.
module aaf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  aaf_pkg::perp_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output aaf_pkg::perp_t  pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aaf_pkg::perp_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not rise on a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("queue count did not fall on a pop");

endmodule

// ----- rtl/aaf_back.sv -----
`timescale 1ns / 1ps

// Back pipeline: normalize, square root, three divider lanes, gain scaling
// and saturation. Every stage moves together when the output register frees.
module aaf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [31:0]  gain,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  aaf_pkg::perp_t      pop_data,
    output logic                out_valid,
    input  logic                out_ready,
    output aaf_pkg::force_t     out_data
);

    localparam int SQ_N = 31;
    localparam int DV_N = 31;
    localparam int NV   = 6 + SQ_N + DV_N + 2;

    typedef struct packed {
        logic [2:0]  negw;
        logic        on_axis;
        logic [63:0] am;
    } side_t;

    function automatic logic [5:0] bitlen32(input logic [31:0] x);
        logic [31:0] y;
        logic [4:0]  p;
        y = x;
        p = '0;
        if (y[31:16] != 16'd0) begin p[4] = 1'b1; y = y >> 16; end
        if (y[15:8] != 8'd0)   begin p[3] = 1'b1; y = y >> 8;  end
        if (y[7:4] != 4'd0)    begin p[2] = 1'b1; y = y >> 4;  end
        if (y[3:2] != 2'd0)    begin p[1] = 1'b1; y = y >> 2;  end
        if (y[1])              begin p[0] = 1'b1;              end
        return (x == 32'd0) ? 6'd0 : {1'b0, p} + 6'd1;
    endfunction

    logic          en;
    logic [NV-1:0] vld_reg;
    logic          out_valid_reg;

    assign en        = !out_valid_reg || out_ready;
    assign pop_ready = en;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NV-2:0], pop_valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    // Normalize: chunk bit lengths, shift amount, shift.
    aaf_pkg::perp_t b0_reg, b1_reg, b2_reg;
    logic [5:0]     bl1_reg [3];
    logic           top1_reg;
    logic [6:0]     sh2_reg, sh_w;
    logic [6:0]     bl_w;
    logic [96:0]    orw;
    logic [2:0][29:0] u3_reg, u4_reg, u5_reg;
    side_t          sb3_reg, sb4_reg, sb5_reg;
    logic [31:0]    mass3_reg;
    logic [59:0]    sq4_reg [3];
    logic [61:0]    sum5_reg;
    logic [31:0]    gain_abs;

    assign orw      = b0_reg.mag[0] | b0_reg.mag[1] | b0_reg.mag[2];
    assign gain_abs = gain[31] ? 32'(-gain) : gain;

    always_comb
    begin
        priority if (top1_reg)               bl_w = 7'd97;
        else if (bl1_reg[2] != 6'd0)         bl_w = 7'd64 + 7'(bl1_reg[2]);
        else if (bl1_reg[1] != 6'd0)         bl_w = 7'd32 + 7'(bl1_reg[1]);
        else                                 bl_w = 7'(bl1_reg[0]);
        sh_w = (bl_w > 7'd30) ? bl_w - 7'd30 : 7'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg     <= pop_data;
            b1_reg     <= b0_reg;
            bl1_reg[0] <= bitlen32(orw[31:0]);
            bl1_reg[1] <= bitlen32(orw[63:32]);
            bl1_reg[2] <= bitlen32(orw[95:64]);
            top1_reg   <= orw[96];
            b2_reg     <= b1_reg;
            sh2_reg    <= sh_w;
            for (int i = 0; i < 3; i++)
            begin
                u3_reg[i]  <= 30'(b2_reg.mag[i] >> sh2_reg);
                sq4_reg[i] <= u3_reg[i] * u3_reg[i];
            end
            sb3_reg.negw    <= b2_reg.negw;
            sb3_reg.on_axis <= b2_reg.on_axis;
            sb3_reg.am      <= '0;
            mass3_reg       <= b2_reg.mass;
            u4_reg          <= u3_reg;
            sb4_reg.negw    <= sb3_reg.negw;
            sb4_reg.on_axis <= sb3_reg.on_axis;
            sb4_reg.am      <= gain_abs * mass3_reg;
            sum5_reg <= 62'(sq4_reg[0]) + 62'(sq4_reg[1]) + 62'(sq4_reg[2]);
            u5_reg   <= u4_reg;
            sb5_reg  <= sb4_reg;
        end
    end

    // Integer square root, one result bit per stage.
    logic [63:0]      sq_x_reg  [SQ_N];
    logic [63:0]      sq_r_reg  [SQ_N];
    logic [2:0][29:0] sq_u_reg  [SQ_N];
    side_t            sq_sb_reg [SQ_N];

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        localparam int BITPOS = 60 - 2 * k;
        logic [63:0]      x_in, r_in, trial;
        logic [2:0][29:0] u_in;
        side_t            sb_in;
        if (k == 0)
        begin : g_first
            assign x_in  = {2'b00, sum5_reg};
            assign r_in  = '0;
            assign u_in  = u5_reg;
            assign sb_in = sb5_reg;
        end
        else
        begin : g_next
            assign x_in  = sq_x_reg[k-1];
            assign r_in  = sq_r_reg[k-1];
            assign u_in  = sq_u_reg[k-1];
            assign sb_in = sq_sb_reg[k-1];
        end
        assign trial = r_in + (64'd1 << BITPOS);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (x_in >= trial)
                begin
                    sq_x_reg[k] <= x_in - trial;
                    sq_r_reg[k] <= (r_in >> 1) + (64'd1 << BITPOS);
                end
                else
                begin
                    sq_x_reg[k] <= x_in;
                    sq_r_reg[k] <= r_in >> 1;
                end
                sq_u_reg[k]  <= u_in;
                sq_sb_reg[k] <= sb_in;
            end
        end
    end

    // Three restoring divider lanes, one quotient bit per stage.
    logic [2:0][31:0] dv_rem_reg [DV_N];
    logic [2:0][30:0] dv_q_reg   [DV_N];
    logic [31:0]      dv_len_reg [DV_N];
    side_t            dv_sb_reg  [DV_N];

    for (genvar k = 0; k < DV_N; k++)
    begin : g_div
        logic [2:0][31:0] rem_in;
        logic [2:0][30:0] q_in;
        logic [2:0]       bit_in;
        logic [31:0]      len_in;
        side_t            sb_in;
        logic [2:0][31:0] rem_nx;
        logic [2:0][30:0] q_nx;
        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = {3'b000, sq_u_reg[SQ_N-1][i][29:1]};
                    bit_in[i] = sq_u_reg[SQ_N-1][i][0];
                end
            end
            assign q_in   = '0;
            assign len_in = (sq_r_reg[SQ_N-1] == 64'd0) ? 32'd1 : sq_r_reg[SQ_N-1][31:0];
            assign sb_in  = sq_sb_reg[SQ_N-1];
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[k-1];
            assign bit_in = '0;
            assign q_in   = dv_q_reg[k-1];
            assign len_in = dv_len_reg[k-1];
            assign sb_in  = dv_sb_reg[k-1];
        end
        always_comb
        begin
            logic [32:0] rs;
            for (int i = 0; i < 3; i++)
            begin
                rs = {rem_in[i], bit_in[i]};
                if (rs >= {1'b0, len_in})
                begin
                    rem_nx[i] = 32'(rs - {1'b0, len_in});
                    q_nx[i]   = {q_in[i][29:0], 1'b1};
                end
                else
                begin
                    rem_nx[i] = rs[31:0];
                    q_nx[i]   = {q_in[i][29:0], 1'b0};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[k] <= rem_nx;
                dv_q_reg[k]   <= q_nx;
                dv_len_reg[k] <= len_in;
                dv_sb_reg[k]  <= sb_in;
            end
        end
    end

    // Gain and mass scaling, then sign and saturation.
    logic [62:0] pl1_reg [3];
    logic [62:0] ph1_reg [3];
    logic [2:0]  neg1_reg, neg2_reg;
    logic        on1_reg, on2_reg;
    logic [48:0] m2_reg [3];
    logic [94:0] p_w [3];
    logic [31:0] f_w [3];
    logic [63:0] am_w;

    assign am_w = dv_sb_reg[DV_N-1].am;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_w[i] = {ph1_reg[i], 32'b0} + 95'(pl1_reg[i]);
            if (on2_reg || m2_reg[i] == 49'd0)
            begin
                f_w[i] = 32'd0;
            end
            else if (neg2_reg[i])
            begin
                f_w[i] = (m2_reg[i] > 49'h0_8000_0000) ? 32'h8000_0000
                                                        : 32'(49'd0 - m2_reg[i]);
            end
            else
            begin
                f_w[i] = (m2_reg[i] > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m2_reg[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl1_reg[i]  <= am_w[31:0] * dv_q_reg[DV_N-1][i];
                ph1_reg[i]  <= am_w[63:32] * dv_q_reg[DV_N-1][i];
                neg1_reg[i] <= gain[31] ^ ~dv_sb_reg[DV_N-1].negw[i];
                m2_reg[i]   <= p_w[i][94:46];
            end
            on1_reg          <= dv_sb_reg[DV_N-1].on_axis;
            neg2_reg         <= neg1_reg;
            on2_reg          <= on1_reg;
            out_data.force_x <= f_w[0];
            out_data.force_y <= f_w[1];
            out_data.force_z <= f_w[2];
            out_data.on_axis <= on2_reg;
        end
    end

endmodule
